FILE: rtl/zigzag_diagonal_scan_core_macros.svh
// Assertion helpers shared by the checker.
`ifndef ZIGZAG_DIAGONAL_SCAN_CORE_MACROS_SVH
`define ZIGZAG_DIAGONAL_SCAN_CORE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define ZDS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define ZDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset.
`define ZDS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/zds_pkg.sv
`default_nettype none
package zds_pkg;

    localparam int SIZE_W    = 4;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } scan_cmd_t;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } scan_state_t;

endpackage
`default_nettype wire

FILE: rtl/zds_load.sv
`default_nettype none
module zds_load
    import zds_pkg::*;
#(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [SIZE_W-1:0]     row_count,
    input  wire logic [SIZE_W-1:0]     col_count,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_WIDTH-1:0] s_element_value,
    output logic                       wr_en,
    output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    output logic [DATA_WIDTH-1:0]      wr_data,
    output logic                       cmd_push,
    output scan_cmd_t                  cmd,
    input  wire logic                  cmd_full,
    input  wire logic                  scan_done
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = 2 * SIZE_W;

    logic [ADDR_W-1:0] load_count_reg;
    logic [ADDR_W-1:0] load_count_next;
    logic              busy_reg;
    logic              busy_next;
    logic [SIZE_W-1:0] rows_eff;
    logic [SIZE_W-1:0] cols_eff;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  count_inc;
    logic              accept;
    logic              emit;

    assign rows_eff = (row_count == '0) ? SIZE_W'(1) :
                      (row_count > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : row_count;
    assign cols_eff = (col_count == '0) ? SIZE_W'(1) :
                      (col_count > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : col_count;

    assign total     = TOT_W'(rows_eff) * TOT_W'(cols_eff);
    assign count_inc = TOT_W'(load_count_reg) + TOT_W'(1);

    assign s_ready = !busy_reg && !cmd_full;
    assign accept  = s_valid && s_ready;
    assign emit    = count_inc >= total;

    assign wr_en    = accept;
    assign wr_addr  = load_count_reg;
    assign wr_data  = s_element_value;
    assign cmd_push = accept && emit;
    assign cmd      = '{rows: rows_eff, cols: cols_eff};

    always_comb begin
        load_count_next = load_count_reg;
        if (accept) begin
            load_count_next = emit ? '0 : count_inc[ADDR_W-1:0];
        end
    end

    // hold off loading until the scan has read the whole store
    always_comb begin
        busy_next = busy_reg;
        if (cmd_push) begin
            busy_next = 1'b1;
        end else if (scan_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            busy_reg       <= 1'b0;
        end else begin
            load_count_reg <= load_count_next;
            busy_reg       <= busy_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/zds_cmd_fifo.sv
`default_nettype none
module zds_cmd_fifo
    import zds_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire scan_cmd_t din,
    output logic           full,
    input  wire logic      pop,
    output logic           valid,
    output scan_cmd_t      dout
);

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    scan_cmd_t         entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = cnt_reg == CNT_W'(FIFO_DEPTH);
    assign valid   = cnt_reg != '0;
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/zds_scan.sv
`default_nettype none
module zds_scan
    import zds_pkg::*;
#(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cmd_valid,
    input  wire scan_cmd_t             cmd,
    output logic                       cmd_pop,
    input  wire logic                  wr_en,
    input  wire logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    output logic                       scan_done,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_WIDTH-1:0]      m_scan_value,
    output logic                       m_scan_last
);

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIN_W    = 2 * SIZE_W;
    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);

    function automatic logic [SIZE_W-1:0] diag_lo(input logic [SIZE_W-1:0] d,
                                                  input logic [SIZE_W-1:0] n_cols);
        logic [SIZE_W-1:0] d1;
        d1 = d + SIZE_W'(1);
        return (d1 > n_cols) ? d1 - n_cols : '0;
    endfunction

    function automatic logic [SIZE_W-1:0] diag_hi(input logic [SIZE_W-1:0] d,
                                                  input logic [SIZE_W-1:0] n_rows);
        logic [SIZE_W-1:0] rm1;
        rm1 = n_rows - SIZE_W'(1);
        return (d < rm1) ? d : rm1;
    endfunction

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    scan_state_t           state_reg;
    scan_state_t           state_next;
    logic [SIZE_W-1:0]     rows_reg;
    logic [SIZE_W-1:0]     cols_reg;
    logic [SIZE_W-1:0]     d_reg;
    logic [SIZE_W-1:0]     r_reg;
    logic                  pend_reg;
    logic                  pend_last_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] ob_value_reg [OB_DEPTH];
    logic                  ob_last_reg [OB_DEPTH];
    logic [OB_PTR_W-1:0]   ob_wr_ptr_reg;
    logic [OB_PTR_W-1:0]   ob_rd_ptr_reg;
    logic [OB_CNT_W-1:0]   ob_cnt_reg;
    logic [OB_CNT_W-1:0]   ob_cnt_next;

    logic [SIZE_W-1:0]     lo_cur;
    logic [SIZE_W-1:0]     hi_cur;
    logic [SIZE_W-1:0]     d_nx;
    logic [SIZE_W-1:0]     lo_nx;
    logic [SIZE_W-1:0]     hi_nx;
    logic [SIZE_W-1:0]     last_d;
    logic                  diag_end;
    logic                  last_item;
    logic [LIN_W-1:0]      lin;
    logic [ADDR_W-1:0]     rd_addr;
    logic [OB_CNT_W-1:0]   occ;
    logic                  ob_pop;
    logic                  space;
    logic                  issue;

    assign lo_cur    = diag_lo(d_reg, cols_reg);
    assign hi_cur    = diag_hi(d_reg, rows_reg);
    assign d_nx      = d_reg + SIZE_W'(1);
    assign lo_nx     = diag_lo(d_nx, cols_reg);
    assign hi_nx     = diag_hi(d_nx, rows_reg);
    assign last_d    = rows_reg + cols_reg - SIZE_W'(2);
    assign diag_end  = d_reg[0] ? (r_reg == hi_cur) : (r_reg == lo_cur);
    assign last_item = diag_end && (d_reg == last_d);

    assign lin     = LIN_W'(r_reg) * LIN_W'(cols_reg) + LIN_W'(d_reg - r_reg);
    assign rd_addr = lin[ADDR_W-1:0];

    assign m_valid      = ob_cnt_reg != '0;
    assign m_scan_value = ob_value_reg[ob_rd_ptr_reg];
    assign m_scan_last  = ob_last_reg[ob_rd_ptr_reg];
    assign ob_pop       = m_valid && m_ready;
    assign occ          = ob_cnt_reg + OB_CNT_W'(pend_reg);
    assign space        = (occ < OB_CNT_W'(OB_DEPTH)) || ob_pop;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE: begin
                if (cmd_valid) begin
                    state_next = SCAN_RUN;
                end
            end
            SCAN_RUN: begin
                if (space && last_item) begin
                    state_next = SCAN_IDLE;
                end
            end
            default: state_next = SCAN_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop   = 1'b0;
        issue     = 1'b0;
        unique case (state_reg)
            SCAN_IDLE: cmd_pop = cmd_valid;
            SCAN_RUN:  issue   = space;
            default: begin
                cmd_pop = 1'b0;
                issue   = 1'b0;
            end
        endcase
        scan_done = issue && last_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // walk the diagonals: even ones upward, odd ones downward
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            rows_reg <= cmd.rows;
            cols_reg <= cmd.cols;
            d_reg    <= '0;
            r_reg    <= '0;
        end else if (issue) begin
            if (diag_end) begin
                d_reg <= d_nx;
                r_reg <= d_nx[0] ? lo_nx : hi_nx;
            end else begin
                r_reg <= d_reg[0] ? r_reg + SIZE_W'(1) : r_reg - SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg   <= mem[rd_addr];
            pend_last_reg <= last_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            ob_value_reg[ob_wr_ptr_reg] <= rd_data_reg;
            ob_last_reg[ob_wr_ptr_reg]  <= pend_last_reg;
        end
    end

    always_comb begin
        ob_cnt_next = ob_cnt_reg;
        if (pend_reg && !ob_pop) begin
            ob_cnt_next = ob_cnt_reg + OB_CNT_W'(1);
        end else if (ob_pop && !pend_reg) begin
            ob_cnt_next = ob_cnt_reg - OB_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_cnt_reg    <= '0;
        end else begin
            pend_reg <= issue;
            if (pend_reg) begin
                ob_wr_ptr_reg <= ob_wr_ptr_reg + OB_PTR_W'(1);
            end
            if (ob_pop) begin
                ob_rd_ptr_reg <= ob_rd_ptr_reg + OB_PTR_W'(1);
            end
            ob_cnt_reg <= ob_cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/zigzag_diagonal_scan_core.sv
// Loading takes one word per cycle while s_ready is high; the word that completes the
// matrix is accepted at once. The first scan word passes through the command queue, the
// store read register and the output buffer; the scan then yields one word per cycle while
// m_ready stays high, read from the element store. Loading resumes once the last store
// read of the scan is issued.
// Reset (aresetn low, synchronous): sizes return to 8 by 8, load count and queues clear.
`default_nettype none
module zigzag_diagonal_scan_core
    import zds_pkg::*;
#(
    parameter int MAX_ROWS   = 8,
    parameter int MAX_COLS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DATA_WIDTH-1:0] s_element_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DATA_WIDTH-1:0]      m_scan_value,
    output logic                       m_scan_last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIZE_W-1:0]     row_count_reg;
    logic [SIZE_W-1:0]     col_count_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  cmd_push;
    scan_cmd_t             cmd_in;
    logic                  cmd_full;
    logic                  cmd_valid;
    scan_cmd_t             cmd_out;
    logic                  cmd_pop;
    logic                  scan_done;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = 32'(row_count_reg);
            REG_COL_COUNT: prdata = 32'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= SIZE_RESET;
            col_count_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ROW_COUNT: row_count_reg <= pwdata[SIZE_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[SIZE_W-1:0];
                default: begin
                    row_count_reg <= row_count_reg;
                end
            endcase
        end
    end

    zds_load #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_load (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .row_count       (row_count_reg),
        .col_count       (col_count_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_value (s_element_value),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .cmd_push        (cmd_push),
        .cmd             (cmd_in),
        .cmd_full        (cmd_full),
        .scan_done       (scan_done)
    );

    zds_cmd_fifo u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .din     (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .valid   (cmd_valid),
        .dout    (cmd_out)
    );

    zds_scan #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd_out),
        .cmd_pop      (cmd_pop),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .scan_done    (scan_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scan_value (m_scan_value),
        .m_scan_last  (m_scan_last)
    );

endmodule
`default_nettype wire

FILE: rtl/zds_checker.sv
`default_nettype none
`include "zigzag_diagonal_scan_core_macros.svh"
module zds_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  pready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [DATA_WIDTH-1:0] m_scan_value,
    input wire logic                  m_scan_last
);

    `ZDS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_scan_value) && $stable(m_scan_last), "stalled result word changed")
    `ZDS_ASSERT_ALWAYS(a_reset_clears, !aresetn, !m_valid, "result word valid straight after reset")
    `ZDS_ASSERT_IMPL(a_valid_known, 1'b1, !$isunknown(m_valid), "result valid unknown")
    `ZDS_ASSERT_IMPL(a_pready_high, 1'b1, pready, "register port not ready")

endmodule

bind zigzag_diagonal_scan_core zds_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_zds_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .pready       (pready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_scan_value (m_scan_value),
    .m_scan_last  (m_scan_last)
);
`default_nettype wire
